// File: design/tof_pkg.sv
package tof_pkg;

    localparam logic [7:0] B_IAC  = 8'hFF;
    localparam logic [7:0] B_WILL = 8'hFB;
    localparam logic [7:0] B_WONT = 8'hFC;
    localparam logic [7:0] B_DO   = 8'hFD;
    localparam logic [7:0] B_DONT = 8'hFE;
    localparam logic [7:0] B_SB   = 8'hFA;
    localparam logic [7:0] B_SE   = 8'hF0;
    localparam logic [7:0] B_CR   = 8'h0D;
    localparam logic [7:0] B_LF   = 8'h0A;
    localparam logic [7:0] B_NUL  = 8'h00;

    typedef enum logic [2:0] {
        ST_NORMAL = 3'd0,
        ST_IAC    = 3'd1,
        ST_VERB   = 3'd2,
        ST_SB     = 3'd3,
        ST_SB_IAC = 3'd4
    } t_filt_state;

    // One processed byte: nothing, one data byte, or a three-byte refusal
    typedef struct packed {
        logic       valid;
        logic       is_reply;
        logic [7:0] reply_verb;
        logic [7:0] data;
    } t_bundle;

    function automatic logic is_verb(input logic [7:0] b);
        is_verb = (b == B_WILL) || (b == B_WONT) || (b == B_DO) || (b == B_DONT);
    endfunction

endpackage

// File: design/tof_filter.sv
module tof_filter (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic             i_cfg_wr_data,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [7:0]       i_in_byte,
    input  logic             i_load_ready,
    output tof_pkg::t_bundle o_bundle,
    output logic             o_load
);

    logic                 r_in_valid;
    logic [7:0]           r_in_byte;
    logic                 r_link_open;
    tof_pkg::t_filt_state r_state;
    tof_pkg::t_filt_state n_state;
    logic [7:0]           r_verb;
    logic [7:0]           n_verb;
    logic                 r_prev_cr;
    logic                 n_prev_cr;
    logic                 adv;

    // Advance the held byte whenever the result stage can take its bundle
    assign adv        = r_in_valid && i_load_ready;
    assign o_in_ready = !r_in_valid || i_load_ready;
    assign o_load     = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_open <= 1'b1;
        end else if (i_cfg_wr_en) begin
            r_link_open <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tof_pkg::ST_NORMAL;
            r_verb    <= 8'h00;
            r_prev_cr <= 1'b0;
        end else if (adv) begin
            r_state   <= n_state;
            r_verb    <= n_verb;
            r_prev_cr <= n_prev_cr;
        end
    end

    always_comb begin
        n_state = tof_pkg::ST_NORMAL;
        case (r_state)
            tof_pkg::ST_IAC: begin
                if (tof_pkg::is_verb(r_in_byte)) begin
                    n_state = tof_pkg::ST_VERB;
                end else if (r_in_byte == tof_pkg::B_SB) begin
                    n_state = tof_pkg::ST_SB;
                end
            end
            tof_pkg::ST_VERB: n_state = tof_pkg::ST_NORMAL;
            tof_pkg::ST_SB: begin
                n_state = (r_in_byte == tof_pkg::B_IAC) ? tof_pkg::ST_SB_IAC
                                                         : tof_pkg::ST_SB;
            end
            tof_pkg::ST_SB_IAC: begin
                n_state = (r_in_byte == tof_pkg::B_IAC) ? tof_pkg::ST_SB
                                                         : tof_pkg::ST_NORMAL;
            end
            default: begin
                n_state = (r_in_byte == tof_pkg::B_IAC) ? tof_pkg::ST_IAC
                                                         : tof_pkg::ST_NORMAL;
            end
        endcase
    end

    always_comb begin
        o_bundle   = '0;
        n_verb     = r_verb;
        n_prev_cr  = r_prev_cr;
        o_bundle.data = r_in_byte;
        case (r_state)
            tof_pkg::ST_IAC: begin
                if (r_in_byte == tof_pkg::B_IAC) begin
                    o_bundle.valid = 1'b1;
                end else if (tof_pkg::is_verb(r_in_byte)) begin
                    n_verb = r_in_byte;
                end
            end
            tof_pkg::ST_VERB: begin
                if (((r_verb == tof_pkg::B_WILL) || (r_verb == tof_pkg::B_DO))
                        && r_link_open) begin
                    o_bundle.valid      = 1'b1;
                    o_bundle.is_reply   = 1'b1;
                    o_bundle.reply_verb = (r_verb == tof_pkg::B_WILL) ? tof_pkg::B_DONT
                                                                       : tof_pkg::B_WONT;
                end
            end
            tof_pkg::ST_SB, tof_pkg::ST_SB_IAC: begin
                o_bundle.valid = 1'b0;
            end
            default: begin
                if (r_in_byte == tof_pkg::B_IAC) begin
                    n_prev_cr = 1'b0;
                end else if (((r_in_byte == tof_pkg::B_NUL) || (r_in_byte == tof_pkg::B_LF))
                        && r_prev_cr) begin
                    // drop a NUL or LF that follows CR
                    n_prev_cr = 1'b0;
                end else begin
                    n_prev_cr      = (r_in_byte == tof_pkg::B_CR);
                    o_bundle.valid = 1'b1;
                end
            end
        endcase
    end

endmodule

// File: design/tof_out.sv
module tof_out (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  tof_pkg::t_bundle i_bundle,
    output logic             o_load_ready,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [7:0]       o_data,
    output logic             o_dest,
    output logic             o_last
);

    logic       r_valid;
    logic       r_is_reply;
    logic [7:0] r_verb;
    logic [7:0] r_data;
    logic [1:0] r_beat;

    assign o_valid      = r_valid;
    assign o_dest       = r_is_reply;
    assign o_last       = !r_is_reply || (r_beat == 2'd2);
    assign o_load_ready = !r_valid || (i_ready && o_last);

    always_comb begin
        o_data = r_data;
        if (r_is_reply) begin
            case (r_beat)
                2'd0:    o_data = tof_pkg::B_IAC;
                2'd1:    o_data = r_verb;
                default: o_data = r_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_beat  <= 2'd0;
        end else if (o_load_ready) begin
            r_valid <= i_load && i_bundle.valid;
            r_beat  <= 2'd0;
        end else if (r_valid && i_ready) begin
            r_beat <= r_beat + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load_ready && i_load) begin
            r_is_reply <= i_bundle.is_reply;
            r_verb     <= i_bundle.reply_verb;
            r_data     <= i_bundle.data;
        end
    end

endmodule

// File: design/telnet_option_filter.sv
// Channel   Dir  tdata          tuser  tlast
// s_axis    in   rx_byte[7:0]   -      -
// m_axis    out  out_byte[7:0]  dest   last
// cfg       in   link_open (i_cfg_wr_data), written when i_cfg_wr_en is high
//
// One received byte is taken per cycle; a data byte goes through the input
// and result registers. A refusal holds the result register for three output
// transfers, and the input register holds one more byte, so intake pauses.
// Synchronous active-low reset empties both registers, returns the filter to
// normal and sets link_open. Output stalls back up through both registers.
module telnet_option_filter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tuser,   // [0] dest
    output logic       m_axis_tlast
);

    tof_pkg::t_bundle bundle;
    logic             load;
    logic             load_ready;

    tof_filter u_filter (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (s_axis_tvalid),
        .o_in_ready    (s_axis_tready),
        .i_in_byte     (s_axis_tdata),
        .i_load_ready  (load_ready),
        .o_bundle      (bundle),
        .o_load        (load)
    );

    tof_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (load),
        .i_bundle     (bundle),
        .o_load_ready (load_ready),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_data       (m_axis_tdata),
        .o_dest       (m_axis_tuser),
        .o_last       (m_axis_tlast)
    );

endmodule

// File: design/tof_checker.sv
module tof_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tuser,
    input logic       m_axis_tlast
);

    // Hold a stalled transfer
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("stalled output changed");

    a_data_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast)
        else $error("host byte without last");

    a_reply_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tuser && !m_axis_tlast) |=>
            (m_axis_tvalid && m_axis_tuser))
        else $error("refusal sequence broken");

    a_reply_verb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser && !m_axis_tlast && (m_axis_tdata != tof_pkg::B_IAC))
            |-> ((m_axis_tdata == tof_pkg::B_DONT) || (m_axis_tdata == tof_pkg::B_WONT)))
        else $error("bad refusal verb");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind telnet_option_filter tof_checker u_tof_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
